@@ design/mi3_pkg.sv @@
package mi3_pkg;

	localparam int unsigned LANES   = 9;
	localparam int unsigned ADJ_W   = 33;
	localparam int unsigned DET_W   = 50;
	localparam int unsigned MAG_W   = 48;
	localparam int unsigned NUM_W   = 58;
	localparam int unsigned DEN_W   = 49;
	localparam int unsigned QUO_W   = 31;
	localparam int unsigned TRIAL_W = DEN_W + QUO_W;
	localparam int unsigned FRAC_SH = 25;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic signed [15:0] a00;
		logic signed [15:0] a01;
		logic signed [15:0] a02;
		logic signed [15:0] a10;
		logic signed [15:0] a11;
		logic signed [15:0] a12;
		logic signed [15:0] a20;
		logic signed [15:0] a21;
		logic signed [15:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] inv00;
		logic signed [31:0] inv01;
		logic signed [31:0] inv02;
		logic signed [31:0] inv10;
		logic signed [31:0] inv11;
		logic signed [31:0] inv12;
		logic signed [31:0] inv20;
		logic signed [31:0] inv21;
		logic signed [31:0] inv22;
		logic               singular;
	} res_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] num;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lanes;
		logic [DEN_W-1:0]  den;
		logic              singular;
	} job_t;

endpackage

@@ design/mi3_front.sv @@
module mi3_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_ready,
	input  mi3_pkg::mat_t mat,
	input  logic          full,
	output logic          push,
	output mi3_pkg::job_t push_data
);
	import mi3_pkg::*;

	logic signed [15:0]      e [3][3];
	logic signed [31:0]      pa_s1 [3][3];
	logic signed [31:0]      pb_s1 [3][3];
	logic signed [15:0]      r0_s1 [3];
	logic signed [ADJ_W-1:0] adj_s2 [3][3];
	logic signed [15:0]      r0_s2 [3];
	logic signed [DEN_W-1:0] dp_s3 [3];
	logic signed [ADJ_W-1:0] adj_s3 [3][3];
	logic signed [DET_W-1:0] det_s4;
	logic signed [ADJ_W-1:0] adj_s4 [3][3];
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    en;
	logic [MAG_W-1:0]        ud;
	logic [DET_W-1:0]        det_abs;
	logic [ADJ_W-1:0]        adj_abs [3][3];

	always_comb begin
		e[0][0] = mat.a00; e[0][1] = mat.a01; e[0][2] = mat.a02;
		e[1][0] = mat.a10; e[1][1] = mat.a11; e[1][2] = mat.a12;
		e[2][0] = mat.a20; e[2][1] = mat.a21; e[2][2] = mat.a22;
	end

	assign en        = !v_s4 || !full;
	assign mat_ready = en;
	assign push      = v_s4 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// cofactor of element (j, i) lands at (i, j)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r0_s1[i] <= e[0][i];
				r0_s2[i] <= r0_s1[i];
				dp_s3[i] <= DEN_W'(r0_s2[i]) * DEN_W'(adj_s2[i][0]);
				for (int j = 0; j < 3; j++) begin
					pa_s1[i][j]  <= e[(j+1)%3][(i+1)%3] * e[(j+2)%3][(i+2)%3];
					pb_s1[i][j]  <= e[(j+1)%3][(i+2)%3] * e[(j+2)%3][(i+1)%3];
					adj_s2[i][j] <= ADJ_W'(pa_s1[i][j]) - ADJ_W'(pb_s1[i][j]);
					adj_s3[i][j] <= adj_s2[i][j];
					adj_s4[i][j] <= adj_s3[i][j];
				end
			end
			det_s4 <= DET_W'(dp_s3[0]) + DET_W'(dp_s3[1]) + DET_W'(dp_s3[2]);
		end
	end

	always_comb begin
		det_abs = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
		ud      = det_abs[MAG_W-1:0];
		push_data.den      = {ud, 1'b0};
		push_data.singular = (det_s4 == '0);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				adj_abs[i][j] = adj_s4[i][j][ADJ_W-1] ? ADJ_W'(-adj_s4[i][j])
				                                      : ADJ_W'(adj_s4[i][j]);
				push_data.lanes[i*3+j].neg = adj_s4[i][j][ADJ_W-1] ^ det_s4[DET_W-1];
				push_data.lanes[i*3+j].num = (NUM_W'(adj_abs[i][j][ADJ_W-2:0]) << FRAC_SH)
				                             + NUM_W'(ud);
			end
		end
	end

endmodule

@@ design/mi3_fifo.sv @@
module mi3_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mi3_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output mi3_pkg::job_t head,
	output logic          empty
);
	import mi3_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/mi3_back.sv @@
module mi3_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mi3_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output mi3_pkg::res_t res
);
	import mi3_pkg::*;

	logic [NUM_W-1:0]   rem_s [QUO_W+1][LANES];
	logic [QUO_W-1:0]   quo_s [QUO_W+1][LANES];
	logic               ovf_s [QUO_W+1][LANES];
	logic               neg_s [QUO_W+1][LANES];
	logic [DEN_W-1:0]   den_s [QUO_W+1];
	logic               sng_s [QUO_W+1];
	logic               vld_s [QUO_W+1];
	logic               ge_c  [QUO_W][LANES];
	logic [NUM_W-1:0]   dif_c [QUO_W][LANES];
	logic [TRIAL_W-1:0] trial_c [QUO_W];
	logic [31:0]        val_c [LANES];
	logic               en;
	logic               res_valid_q;
	res_t               res_q;

	assign en        = !res_valid_q || res_ready;
	assign pop       = en && !empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// stage k sets quotient bit QUO_W-1-k
	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			trial_c[k] = {den_s[k], QUO_W'(0)} >> (k + 1);
			for (int l = 0; l < LANES; l++) begin
				ge_c[k][l]  = TRIAL_W'(rem_s[k][l]) >= trial_c[k];
				dif_c[k][l] = rem_s[k][l] - trial_c[k][NUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) begin
				vld_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !empty;
			for (int k = 1; k <= QUO_W; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			res_valid_q <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= head.den;
			sng_s[0] <= head.singular;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= head.lanes[l].num;
				neg_s[0][l] <= head.lanes[l].neg;
				quo_s[0][l] <= '0;
				ovf_s[0][l] <= TRIAL_W'(head.lanes[l].num) >= {head.den, QUO_W'(0)};
			end
			for (int k = 1; k <= QUO_W; k++) begin
				den_s[k] <= den_s[k-1];
				sng_s[k] <= sng_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= ge_c[k-1][l] ? dif_c[k-1][l] : rem_s[k-1][l];
					quo_s[k][l] <= quo_s[k-1][l]
					               | (QUO_W'(ge_c[k-1][l]) << (QUO_W - k));
					ovf_s[k][l] <= ovf_s[k-1][l];
					neg_s[k][l] <= neg_s[k-1][l];
				end
			end
			res_q.inv00    <= val_c[0];
			res_q.inv01    <= val_c[1];
			res_q.inv02    <= val_c[2];
			res_q.inv10    <= val_c[3];
			res_q.inv11    <= val_c[4];
			res_q.inv12    <= val_c[5];
			res_q.inv20    <= val_c[6];
			res_q.inv21    <= val_c[7];
			res_q.inv22    <= val_c[8];
			res_q.singular <= sng_s[QUO_W];
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (sng_s[QUO_W]) begin
				val_c[l] = (l % 4 == 0) ? ONE_Q16 : '0;
			end else if (ovf_s[QUO_W][l]) begin
				val_c[l] = neg_s[QUO_W][l] ? SAT_NEG : SAT_POS;
			end else if (neg_s[QUO_W][l]) begin
				val_c[l] = -{1'b0, quo_s[QUO_W][l]};
			end else begin
				val_c[l] = {1'b0, quo_s[QUO_W][l]};
			end
		end
	end

endmodule

@@ design/matrix3x3_inverse.sv @@
// 3x3 matrix inverse by adjugate, Q8.8 in, Q16.16 out
// mat channel: one beat carries a whole matrix, row-major, nine signed
//   Q8.8 elements; taken when mat_valid and mat_ready are both high
// res channel: one beat per matrix with nine signed Q16.16 inverse
//   elements, rounded to nearest (ties away from zero) and saturated,
//   plus the singular flag; a zero determinant gives the identity
// throughput: one matrix per cycle while res_ready does not stall, with the bit-per-stage divider
//   pipeline serving all nine elements of a matrix at once
// datapath: a matrix passes four cofactor/determinant stages, one through
//   the job queue, 32 divider stages and the output register
// a res stall freezes only the divider pipeline and output register; the cofactor
//   stages keep filling the job queue and mat_ready drops once it is full
// reset clears all valid flags and the queue; no result is shown until
//   a matrix has been taken after reset
module matrix3x3_inverse #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_ready,
	input  mi3_pkg::mat_t mat,
	output logic          res_valid,
	input  logic          res_ready,
	output mi3_pkg::res_t res
);
	import mi3_pkg::*;

	job_t push_data, head;
	logic push, full, pop, empty;

	mi3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	mi3_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	mi3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ design/mi3_checker.sv @@
module mi3_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          mat_valid,
	input logic          mat_ready,
	input mi3_pkg::mat_t mat,
	input logic          res_valid,
	input logic          res_ready,
	input mi3_pkg::res_t res
);
	import mi3_pkg::*;

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// singular results are the identity
	a_sing_ident: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.singular |->
			res.inv00 == ONE_Q16 && res.inv11 == ONE_Q16 && res.inv22 == ONE_Q16 &&
			res.inv01 == '0 && res.inv02 == '0 && res.inv10 == '0 &&
			res.inv12 == '0 && res.inv20 == '0 && res.inv21 == '0)
		else $error("singular result is not the identity");

	// nothing shown while in reset
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	// no result right after reset release
	a_rst_first: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid straight after reset");

endmodule

bind matrix3x3_inverse mi3_checker u_chk (.*);

@@ bench/tb_matrix3x3_inverse.sv @@
module tb_matrix3x3_inverse;
	import mi3_pkg::*;

	localparam int LATENCY = 37;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_ready;
	mat_t mat = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	res_t inverse_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit sending_done = 1'b0;
	bit long_hold = 1'b0;

	matrix3x3_inverse uut (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #10 clk = ~clk;

	// rounded, saturated quotient of adjugate element over determinant
	function automatic logic [31:0] quotient_q16(longint num, longint den);
		bit neg;
		logic [63:0] un, ud, q;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		q = (2 * un + ud) / (2 * ud);
		if (neg)
			return (q >= 64'h8000_0000) ? SAT_NEG : 32'(-q);
		return (q >= 64'h7FFF_FFFF) ? SAT_POS : q[31:0];
	endfunction

	function automatic res_t invert_matrix(mat_t m);
		longint e[3][3];
		longint adj[3][3];
		longint det;
		logic [31:0] o[9];
		res_t r;
		e[0][0] = m.a00; e[0][1] = m.a01; e[0][2] = m.a02;
		e[1][0] = m.a10; e[1][1] = m.a11; e[1][2] = m.a12;
		e[2][0] = m.a20; e[2][1] = m.a21; e[2][2] = m.a22;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				adj[i][j] = e[(j+1)%3][(i+1)%3] * e[(j+2)%3][(i+2)%3]
					- e[(j+1)%3][(i+2)%3] * e[(j+2)%3][(i+1)%3];
		det = e[0][0] * adj[0][0] + e[0][1] * adj[1][0] + e[0][2] * adj[2][0];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (det == 0)
					o[i*3+j] = (i == j) ? ONE_Q16 : '0;
				else
					o[i*3+j] = quotient_q16(adj[i][j] * (longint'(1) << 24), det);
		r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], det == 0};
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", field, got, want);
		errors++;
	endtask

	// valid stays high into the next beat when no gap is drawn
	task automatic send_matrix(mat_t m, int gap);
		mat_valid <= 1'b1;
		mat <= m;
		@(posedge clk);
		while (!mat_ready) @(posedge clk);
		inverse_q.push_back(invert_matrix(m));
		if (gap != 0) begin
			mat_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// identity, extremes, singular cases, diagonals and full matrices
	mat_t directed_rows[] = '{
		{16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100},
		'0,
		{9{16'h7FFF}},
		{9{16'h8000}},
		{9{16'hFFFF}},
		{16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000},
		{16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF},
		{16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001},
		{16'h0200, 16'h0, 16'h0, 16'h0, 16'h0300, 16'h0, 16'h0, 16'h0, 16'hFC00},
		{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
			16'h0700, 16'h0800, 16'h0900},
		{16'h0100, 16'h0200, 16'h0300, 16'h0, 16'h0100, 16'h0400,
			16'h0500, 16'h0600, 16'h0},
		{16'h0003, 16'h0, 16'h0, 16'h0, 16'h0003, 16'h0, 16'h0, 16'h0, 16'h0003},
		{16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF,
			16'h1234, 16'hEDCB, 16'h0F0F}
	};
	// typed-in results: identity, zero matrix, two all-equal matrices
	res_t directed_want[4] = '{
		{ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 1'b0},
		{ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 1'b1},
		{ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 1'b1},
		{ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 1'b1}
	};

	initial begin
		mat_t m;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[k]) begin
			if (k < 4 && invert_matrix(directed_rows[k]) !== directed_want[k])
				report_mismatch("table", 32'(k), 32'd0);
			send_matrix(directed_rows[k], $urandom_range(0, 11));
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) long_hold = 1'b1;
			if (n == 700) begin
				mat_valid <= 1'b0;
				@(posedge clk);
				while (inverse_q.size() != 0) @(posedge clk);
			end
			m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
				rand_elem(), rand_elem(), rand_elem(), rand_elem()};
			if ($urandom_range(0, 3) == 0)
				m = {m.a00, m.a01, m.a02, m.a00, m.a01, m.a02, m.a20, m.a21, m.a22};
			if ($urandom_range(0, 2) == 0)
				send_matrix(m, $urandom_range(0, 11));
			else
				send_matrix(m, 0);
		end
		mat_valid <= 1'b0;
		sending_done = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (inverse_q.size() == 0) begin
					report_mismatch("unexpected beat", 32'd0, 32'd0);
				end else begin
					res_t w;
					w = inverse_q.pop_front();
					if (res.inv00 !== w.inv00) report_mismatch("inv00", res.inv00, w.inv00);
					if (res.inv01 !== w.inv01) report_mismatch("inv01", res.inv01, w.inv01);
					if (res.inv02 !== w.inv02) report_mismatch("inv02", res.inv02, w.inv02);
					if (res.inv10 !== w.inv10) report_mismatch("inv10", res.inv10, w.inv10);
					if (res.inv11 !== w.inv11) report_mismatch("inv11", res.inv11, w.inv11);
					if (res.inv12 !== w.inv12) report_mismatch("inv12", res.inv12, w.inv12);
					if (res.inv20 !== w.inv20) report_mismatch("inv20", res.inv20, w.inv20);
					if (res.inv21 !== w.inv21) report_mismatch("inv21", res.inv21, w.inv21);
					if (res.inv22 !== w.inv22) report_mismatch("inv22", res.inv22, w.inv22);
					if (res.singular !== w.singular)
						report_mismatch("singular", 32'(res.singular), 32'(w.singular));
				end
			end
			if ((res_valid && res_ready) || (mat_valid && mat_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, one long hold to fill the queue
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				res_ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (wait_n != 0) begin
				res_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
			if (sending_done && inverse_q.size() == 0) begin
				repeat (LATENCY * 2) @(posedge clk);
				if (errors == 0 && inverse_q.size() == 0)
					$display("status: pass");
				else
					$display("status: fail");
				$finish;
			end
		end
	end

endmodule

@@ sim.f @@
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_fifo.sv
design/mi3_back.sv
design/matrix3x3_inverse.sv
design/mi3_checker.sv
bench/tb_matrix3x3_inverse.sv
